>>> hdl/assert_macros.svh
// Assertion macros shared by the alpha unpremultiply RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/aup_pkg.sv
// Shared constants and types for the alpha unpremultiply pixel stream.
package aup_pkg;

  localparam int MAX_DIMENSION = 16384;
  localparam int POS_W         = $clog2(MAX_DIMENSION);
  localparam int SIZE_W        = 15;
  localparam int CHAN_W        = 8;
  localparam int PIXEL_W       = 4 * CHAN_W;
  localparam int PROD_W        = 2 * CHAN_W;
  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

  // One quotient bit per divider step
  localparam int STEPS = CHAN_W;
  localparam int CNT_W = $clog2(STEPS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic last_in_row;
    logic last_in_page;
  } pos_flags_t;

endpackage

>>> hdl/aup_lane.sv
// Color lane: bit-serial restoring chan*255/alpha divide; saturates or passes chan.
`include "assert_macros.svh"

module aup_lane
  import aup_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  logic [CHAN_W-1:0] chan,
  input  logic [CHAN_W-1:0] alpha,
  output logic [CHAN_W-1:0] result
);

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_SAT,
    MODE_DIV
  } lane_mode_t;

  lane_mode_t        mode;
  logic [CHAN_W-1:0] chan_q;
  logic [CHAN_W-1:0] alpha_q;
  logic [CHAN_W-1:0] rem;
  logic [CHAN_W-1:0] low;
  logic [CHAN_W-1:0] quo;

  logic [PROD_W-1:0] prod;
  logic [CHAN_W:0]   rem_sh;
  logic [CHAN_W:0]   rem_sub;
  logic              fits;
  lane_mode_t        mode_next;

  // chan*255 as (chan << 8) - chan
  assign prod = {chan, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, chan};

  // Shift in the next dividend bit and trial-subtract alpha
  assign rem_sh  = {rem, low[CHAN_W-1]};
  assign rem_sub = rem_sh - {1'b0, alpha_q};
  assign fits    = (rem_sh >= {1'b0, alpha_q});

  // Pick the lane mode for a new item: alpha 0 or max passes, else chan >= alpha saturates
  always_comb begin
    if ((alpha == '0) || (alpha == CHAN_MAX)) begin
      mode_next = MODE_PASS;
    end else if (chan >= alpha) begin
      mode_next = MODE_SAT;
    end else begin
      mode_next = MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PASS;
    end else if (ctrl.load) begin
      mode <= mode_next;
    end
  end

  // Load operands, then advance one quotient bit per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      chan_q  <= chan;
      alpha_q <= alpha;
      rem     <= prod[PROD_W-1:CHAN_W];
      low     <= prod[CHAN_W-1:0];
      quo     <= '0;
    end else if (ctrl.step) begin
      rem <= fits ? rem_sub[CHAN_W-1:0] : rem_sh[CHAN_W-1:0];
      low <= {low[CHAN_W-2:0], 1'b0};
      quo <= {quo[CHAN_W-2:0], fits};
    end
  end

  always_comb begin
    case (mode)
      MODE_PASS: result = chan_q;
      MODE_SAT:  result = CHAN_MAX;
      MODE_DIV:  result = quo;
      default:   result = chan_q;
    endcase
  end

  `ASSERT_IMPLIES(a_rem_below_alpha, clk, rst, (mode == MODE_DIV), (rem < alpha_q), "lane remainder not below alpha")

endmodule

>>> hdl/aup_position.sv
// Page size registers and column/row counters that flag row and page ends.
`include "assert_macros.svh"

module aup_position
  import aup_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 advance,
  output pos_flags_t           flags
);

  logic [SIZE_W-1:0] page_width;
  logic [SIZE_W-1:0] page_height;
  logic [POS_W-1:0]  column;
  logic [POS_W-1:0]  row;

  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;
  logic [SIZE_W-1:0] column_inc;
  logic [SIZE_W-1:0] row_inc;

  // Clamp sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (page_width == '0) begin
      width_eff = SIZE_W'(1);
    end else if (page_width > SIZE_W'(MAX_DIMENSION)) begin
      width_eff = SIZE_W'(MAX_DIMENSION);
    end else begin
      width_eff = page_width;
    end
    if (page_height == '0) begin
      height_eff = SIZE_W'(1);
    end else if (page_height > SIZE_W'(MAX_DIMENSION)) begin
      height_eff = SIZE_W'(MAX_DIMENSION);
    end else begin
      height_eff = page_height;
    end
  end

  assign column_inc         = SIZE_W'(column) + SIZE_W'(1);
  assign row_inc            = SIZE_W'(row) + SIZE_W'(1);
  assign flags.last_in_row  = (column_inc >= width_eff);
  assign flags.last_in_page = flags.last_in_row && (row_inc >= height_eff);

  // Hold the page size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_width  <= SIZE_W'(1);
      page_height <= SIZE_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAGE_WIDTH:  page_width  <= cfg_data;
        REG_PAGE_HEIGHT: page_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the counters once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      if (flags.last_in_row) begin
        column <= '0;
        row    <= flags.last_in_page ? '0 : row_inc[POS_W-1:0];
      end else begin
        column <= column_inc[POS_W-1:0];
      end
    end
  end

  `ASSERT_NEXT(a_page_wrap, clk, rst, (advance && flags.last_in_page), ((column == '0) && (row == '0)), "counters did not wrap at page end")

endmodule

>>> hdl/alpha_unpremultiply_pixel_stream_top.sv
// Top level: one pixel at a time through three divider lanes and a merging output register.
// A result is shown in the output register once every divide step is done and
// the output register is free; a new item is accepted only after that merge. The
// 8-step bit-serial divide in the color lanes sets this pace.
// Reset: synchronous, clears the page size registers to 1, the column and row
// counters to 0, and drops every valid flag.
`include "assert_macros.svh"

module alpha_unpremultiply_pixel_stream_top
  import aup_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIXEL_W-1:0]   packed_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [CHAN_W-1:0]    out_alpha,
  output logic                 last_in_row,
  output logic                 last_in_page,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [CHAN_W-1:0] alpha_q;
  pos_flags_t        flags_q;
  pos_flags_t        flags;
  lane_ctrl_t        ctrl;
  logic              accept;
  logic              merge;
  logic [CHAN_W-1:0] red_res;
  logic [CHAN_W-1:0] green_res;
  logic [CHAN_W-1:0] blue_res;
  logic [CHAN_W-1:0] alpha_in;

  assign alpha_in  = packed_pixel[4*CHAN_W-1:3*CHAN_W];
  assign in_ready  = !busy && !done;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign merge     = done && (!out_valid || out_ready);
  assign ctrl.load = accept;
  assign ctrl.step = busy;

  aup_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .flags     (flags)
  );

  aup_lane u_lane_red (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .chan   (packed_pixel[3*CHAN_W-1:2*CHAN_W]),
    .alpha  (alpha_in),
    .result (red_res)
  );

  aup_lane u_lane_green (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .chan   (packed_pixel[2*CHAN_W-1:CHAN_W]),
    .alpha  (alpha_in),
    .result (green_res)
  );

  aup_lane u_lane_blue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .chan   (packed_pixel[CHAN_W-1:0]),
    .alpha  (alpha_in),
    .result (blue_res)
  );

  // Sequence the lanes: load on accept, then step until every quotient bit is in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (merge) begin
        done <= 1'b0;
      end
    end
  end

  // Keep alpha and the position flags alongside the item
  always_ff @(posedge clk) begin
    if (accept) begin
      alpha_q <= alpha_in;
      flags_q <= flags;
    end
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (merge) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge) begin
      out_red      <= red_res;
      out_green    <= green_res;
      out_blue     <= blue_res;
      out_alpha    <= alpha_q;
      last_in_row  <= flags_q.last_in_row;
      last_in_page <= flags_q.last_in_page;
    end
  end

  `ASSERT_IMPLIES(a_done_not_busy, clk, rst, done, !busy, "lanes still busy while result pending")
  `ASSERT_NEXT(a_finish_sets_done, clk, rst, (busy && (count == CNT_W'(STEPS - 1))), done, "final divide step did not mark result done")
  `ASSERT_NEXT(a_merge_shows, clk, rst, merge, out_valid, "merged result not shown")

endmodule
